@@ rtl/piws_pkg.sv @@
// Shared types and constants of the panel init word sequencer.
package piws_pkg;

	localparam int FRAME_BITS_DEF = 9;

	localparam int WORD_W  = 16;
	localparam int LOW_W   = 8;
	localparam int HIGH_W  = 8;
	localparam int UNIT_W  = 10;
	localparam int HOLD_W  = 26;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_LOW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UNIT = CFG_IDX_W'(3);

	localparam logic [WORD_W-1:0] ESCAPE_RST     = 16'hFFFF;
	localparam logic [LOW_W-1:0]  CLOCK_LOW_RST  = 8'd3;
	localparam logic [HIGH_W-1:0] CLOCK_HIGH_RST = 8'd10;
	localparam logic [UNIT_W-1:0] DELAY_UNIT_RST = 10'd1000;

	localparam logic [HOLD_W-1:0] GUARD_LOW_US  = 26'd1;
	localparam logic [HOLD_W-1:0] CLOSE_HOLD_US = 26'd6;

	// one queued job: a frame (arg holds the word) or a delay (arg holds the hold time)
	typedef struct packed {
		logic              is_delay;
		logic [HOLD_W-1:0] arg;
	} piws_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} piws_qstat_t;

	typedef struct packed {
		logic [LOW_W-1:0]  clock_low;
		logic [HIGH_W-1:0] clock_high;
	} piws_timing_t;

endpackage

@@ rtl/piws_if.sv @@
// Handshake channels: table words in, pin events out, register writes.
interface piws_word_if import piws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] table_word;
	modport source (output valid, output table_word, input ready);
	modport sink (input valid, input table_word, output ready);
endinterface

interface piws_evt_if import piws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              chip_select;
	logic              serial_clock;
	logic              serial_data;
	logic [HOLD_W-1:0] hold_us;
	logic              last_event;
	modport source (output valid, output chip_select, output serial_clock,
		output serial_data, output hold_us, output last_event, input ready);
	modport sink (input valid, input chip_select, input serial_clock,
		input serial_data, input hold_us, input last_event, output ready);
endinterface

interface piws_cfg_if import piws_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/piws_front.sv @@
// Front end: accepts table words, tracks the delay escape and queues jobs.
module piws_front import piws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	piws_word_if.sink         words,
	input  logic [WORD_W-1:0] escape_marker,
	input  logic [UNIT_W-1:0] delay_unit,
	input  piws_qstat_t       qstat,
	output logic              push,
	output piws_entry_t       push_entry
);

	logic armed_q;
	logic accept;

	assign words.ready = !qstat.full;
	assign accept      = words.valid && words.ready;

	// an armed word becomes a delay; the escape marker itself only arms
	always_comb begin
		push_entry.is_delay = armed_q;
		if (armed_q) begin
			push_entry.arg = HOLD_W'(words.table_word) * HOLD_W'(delay_unit);
		end else begin
			push_entry.arg = HOLD_W'(words.table_word);
		end
		push = accept && (armed_q || (words.table_word != escape_marker));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (accept) begin
			if (armed_q) begin
				armed_q <= 1'b0;
			end else if (words.table_word == escape_marker) begin
				armed_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/piws_queue.sv @@
// Short job queue between front and back end.
module piws_queue import piws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  piws_entry_t push_entry,
	input  logic        pop,
	output piws_entry_t head,
	output piws_qstat_t qstat
);

	piws_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign qstat.valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/piws_back.sv @@
// Back end: steps through the pin events of a job into the output register.
module piws_back import piws_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  piws_timing_t timing,
	input  piws_entry_t  head,
	input  piws_qstat_t  qstat,
	output logic         pop,
	piws_evt_if.source   events
);

	localparam int STEPS  = 2 * FRAME_BITS + 2;
	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	logic                  valid_q;
	logic                  cs_q;
	logic                  clk_q;
	logic                  data_q;
	logic [HOLD_W-1:0]     hold_q;
	logic                  last_q;
	logic                  active_q;
	logic [STEP_W-1:0]     step_q;
	logic [FRAME_BITS-1:0] sh_q;

	logic              adv;
	logic              ev_cs;
	logic              ev_clk;
	logic              ev_data;
	logic [HOLD_W-1:0] ev_hold;
	logic              ev_last;

	assign adv = !valid_q || events.ready;
	assign pop = adv && !active_q && qstat.valid;

	assign events.valid        = valid_q;
	assign events.chip_select  = cs_q;
	assign events.serial_clock = clk_q;
	assign events.serial_data  = data_q;
	assign events.hold_us      = hold_q;
	assign events.last_event   = last_q;

	// event of the current step of a running frame
	always_comb begin
		ev_cs   = 1'b0;
		ev_clk  = 1'b0;
		ev_data = data_q;
		ev_hold = HOLD_W'(timing.clock_high);
		ev_last = 1'b0;
		if (step_q == LAST_STEP) begin
			ev_cs   = 1'b1;
			ev_hold = CLOSE_HOLD_US;
			ev_last = 1'b1;
		end else if (step_q[0]) begin
			ev_data = sh_q[FRAME_BITS-1];
			ev_hold = HOLD_W'(timing.clock_low);
		end else begin
			ev_clk  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			cs_q     <= 1'b1;
			clk_q    <= 1'b0;
			data_q   <= 1'b1;
			hold_q   <= '0;
			last_q   <= 1'b0;
			active_q <= 1'b0;
			step_q   <= '0;
			sh_q     <= '0;
		end else if (adv) begin
			if (active_q) begin
				valid_q <= 1'b1;
				cs_q    <= ev_cs;
				clk_q   <= ev_clk;
				data_q  <= ev_data;
				hold_q  <= ev_hold;
				last_q  <= ev_last;
				step_q  <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					active_q <= 1'b0;
				end else if (step_q[0]) begin
					sh_q <= sh_q << 1;
				end
			end else if (qstat.valid) begin
				valid_q <= 1'b1;
				if (head.is_delay) begin
					// keep the pins, hold them for the delay
					hold_q <= head.arg;
					last_q <= 1'b1;
				end else begin
					// open the frame: select low, data high
					cs_q     <= 1'b0;
					clk_q    <= 1'b0;
					data_q   <= 1'b1;
					hold_q   <= HOLD_W'(timing.clock_high) + GUARD_LOW_US;
					last_q   <= 1'b0;
					active_q <= 1'b1;
					step_q   <= STEP_W'(1);
					sh_q     <= head.arg[FRAME_BITS-1:0];
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/panel_init_word_sequencer.sv @@
// Top level of the panel init word sequencer: registers, front, queue, back.
//
// Usage:
//   words  - table words in. A command word is framed as FRAME_BITS bits, MSB
//            first, giving 2*FRAME_BITS+2 pin events (20 at the default of 9).
//            A word equal to the escape marker gives no event and arms a
//            delay; the next word gives one event that keeps the pins and
//            holds them for word * delay_unit_us.
//   events - pin events out: chip select, clock, data, hold time in us, and a
//            flag on the last event of each word.
//   cfg    - register writes, always ready; write only while idle.
// An accepted word is stored in the job queue; the back end then loads its
//   first event into the output register.
// The back end emits one event per cycle while the output channel is ready;
//   a command word gives 2*FRAME_BITS+2 events and a delay word one.
// The front end keeps accepting words while the back end works, until the
//   two-entry job queue is full.
// Reset: registers return to their defaults, pins to select high, clock low,
//   data high, and the queue empties.
// Receiver stall: the output register holds its event and the back end
//   stalls; the front end fills the queue and then drops words.ready.
module panel_init_word_sequencer import piws_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	piws_word_if.sink  words,
	piws_evt_if.source events,
	piws_cfg_if.sink   cfg
);

	logic [WORD_W-1:0] escape_q;
	logic [LOW_W-1:0]  clock_low_q;
	logic [HIGH_W-1:0] clock_high_q;
	logic [UNIT_W-1:0] delay_unit_q;

	piws_timing_t timing;
	piws_qstat_t  qstat;
	piws_entry_t  push_entry;
	piws_entry_t  head;
	logic         push;
	logic         pop;

	// writes always land at once; an unknown index is ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q     <= ESCAPE_RST;
			clock_low_q  <= CLOCK_LOW_RST;
			clock_high_q <= CLOCK_HIGH_RST;
			delay_unit_q <= DELAY_UNIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ESCAPE:     escape_q     <= cfg.data;
				CFG_CLOCK_LOW:  clock_low_q  <= cfg.data[LOW_W-1:0];
				CFG_CLOCK_HIGH: clock_high_q <= cfg.data[HIGH_W-1:0];
				CFG_DELAY_UNIT: delay_unit_q <= cfg.data[UNIT_W-1:0];
				default:        escape_q     <= escape_q;
			endcase
		end
	end

	assign timing.clock_low  = clock_low_q;
	assign timing.clock_high = clock_high_q;

	// classify words and build jobs
	piws_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.words         (words),
		.escape_marker (escape_q),
		.delay_unit    (delay_unit_q),
		.qstat         (qstat),
		.push          (push),
		.push_entry    (push_entry)
	);

	// decouple the two sides
	piws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// advance through pin events
	piws_back #(
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.timing (timing),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.events (events)
	);

endmodule

@@ rtl/piws_checker.sv @@
// Port checks of the panel init word sequencer, bound to the top level.
module piws_checker import piws_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic out_cs,
	input logic out_sclk,
	input logic out_last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("event dropped while stalled");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_cs && !out_sclk)
		else $error("last event leaves pins active");

	a_clock_selected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sclk |-> !out_cs)
		else $error("clock high while deselected");

	a_frame_selected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !out_cs)
		else $error("mid-frame event with select high");

endmodule

bind panel_init_word_sequencer piws_checker u_piws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (events.valid),
	.out_ready (events.ready),
	.out_cs    (events.chip_select),
	.out_sclk  (events.serial_clock),
	.out_last  (events.last_event)
);
